>>> hdl/gsp_pkg.sv
// ----------------------------------------------------------------------------
// gsp_pkg
// shared types, codes and constants of the gauss-seidel poisson solver
// ----------------------------------------------------------------------------
package gsp_pkg;

   localparam int VAL_W         = 32;     // signed q16.16 value width
   localparam int SUM_W         = 52;     // stencil accumulator width
   localparam int DEF_MAX_ROWS  = 64;
   localparam int DEF_MAX_COLS  = 64;
   localparam int CSR_AW        = 5;

   // operations
   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_SOLVE = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   // result kinds
   localparam logic KIND_SOLVE = 1'b0;
   localparam logic KIND_READ  = 1'b1;

   // register indexes
   localparam logic [2:0] REG_GRID_ROWS  = 3'd0;
   localparam logic [2:0] REG_GRID_COLS  = 3'd1;
   localparam logic [2:0] REG_WEIGHT_X   = 3'd2;
   localparam logic [2:0] REG_WEIGHT_Y   = 3'd3;
   localparam logic [2:0] REG_WEIGHT_RHO = 3'd4;
   localparam logic [2:0] REG_TOLERANCE  = 3'd5;
   localparam logic [2:0] REG_MAX_SWEEPS = 3'd6;
   localparam logic [2:0] REG_CHECK_INT  = 3'd7;

   // potential read address select
   localparam logic [2:0] RS_REQ    = 3'd0;
   localparam logic [2:0] RS_UP     = 3'd1;
   localparam logic [2:0] RS_DOWN   = 3'd2;
   localparam logic [2:0] RS_LEFT   = 3'd3;
   localparam logic [2:0] RS_RIGHT  = 3'd4;
   localparam logic [2:0] RS_CENTER = 3'd5;

   // read data capture
   localparam logic [2:0] CAP_NONE   = 3'd0;
   localparam logic [2:0] CAP_SX_LD  = 3'd1;
   localparam logic [2:0] CAP_SX_ADD = 3'd2;
   localparam logic [2:0] CAP_SY_LD  = 3'd3;
   localparam logic [2:0] CAP_SY_ADD = 3'd4;
   localparam logic [2:0] CAP_CENTER = 3'd5;

   // multiplier operand select
   localparam logic [1:0] MUL_NONE = 2'd0;
   localparam logic [1:0] MUL_RHO  = 2'd1;
   localparam logic [1:0] MUL_X    = 2'd2;
   localparam logic [1:0] MUL_Y    = 2'd3;

   // accumulator operation
   localparam logic [1:0] ACC_NONE   = 2'd0;
   localparam logic [1:0] ACC_LD_RHO = 2'd1;
   localparam logic [1:0] ACC_ADD_NB = 2'd2;

   typedef struct packed {
      logic [6:0]  grid_rows;
      logic [6:0]  grid_columns;
      logic [31:0] weight_x;
      logic [31:0] weight_y;
      logic [31:0] weight_rho;
      logic [30:0] tolerance;
      logic [15:0] max_sweeps;
      logic [15:0] check_interval;
   } cfg_type;

   typedef struct packed {
      logic        rd_en;
      logic [2:0]  rd_sel;
      logic        ch_rd_en;
      logic [2:0]  cap;
      logic [1:0]  mul_sel;
      logic [1:0]  acc_op;
      logic        load_wr;
      logic        solve_wr;
      logic        out_load;
      logic        out_kind;
      logic        out_zero;
      logic        converged;
      logic [15:0] sweeps;
   } cmd_type;

endpackage

>>> hdl/gsp_if.sv
// ----------------------------------------------------------------------------
// gsp channel interfaces
// request and response words with valid/ready handshake
// ----------------------------------------------------------------------------
interface gsp_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [5:0]  row;
   logic [5:0]  column;
   logic signed [31:0] charge_value;
   logic signed [31:0] potential_value;

   modport source (output valid, operation, row, column, charge_value, potential_value,
                   input ready);
   modport sink   (input valid, operation, row, column, charge_value, potential_value,
                   output ready);
endinterface

interface gsp_rsp_if;
   logic        valid;
   logic        ready;
   logic        result_kind;
   logic signed [31:0] potential_out;
   logic        converged;
   logic [15:0] sweeps_done;

   modport source (output valid, result_kind, potential_out, converged, sweeps_done,
                   input ready);
   modport sink   (input valid, result_kind, potential_out, converged, sweeps_done,
                   output ready);
endinterface

>>> hdl/gsp_csr.sv
// ----------------------------------------------------------------------------
// gsp_csr
// apb register file for grid size, weights and solve limits
// ----------------------------------------------------------------------------
module gsp_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [gsp_pkg::CSR_AW-1:0]  paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready,
   output gsp_pkg::cfg_type            cfg
);

   gsp_pkg::cfg_type cfg_ff, cfg_in;
   logic [2:0]       idx;
   logic             wr;

   assign idx    = paddr[4:2];
   assign wr     = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         unique case (idx)
            gsp_pkg::REG_GRID_ROWS:  cfg_in.grid_rows      = pwdata[6:0];
            gsp_pkg::REG_GRID_COLS:  cfg_in.grid_columns   = pwdata[6:0];
            gsp_pkg::REG_WEIGHT_X:   cfg_in.weight_x       = pwdata;
            gsp_pkg::REG_WEIGHT_Y:   cfg_in.weight_y       = pwdata;
            gsp_pkg::REG_WEIGHT_RHO: cfg_in.weight_rho     = pwdata;
            gsp_pkg::REG_TOLERANCE:  cfg_in.tolerance      = pwdata[30:0];
            gsp_pkg::REG_MAX_SWEEPS: cfg_in.max_sweeps     = pwdata[15:0];
            gsp_pkg::REG_CHECK_INT:  cfg_in.check_interval = pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         gsp_pkg::REG_GRID_ROWS:  prdata = {25'd0, cfg_ff.grid_rows};
         gsp_pkg::REG_GRID_COLS:  prdata = {25'd0, cfg_ff.grid_columns};
         gsp_pkg::REG_WEIGHT_X:   prdata = cfg_ff.weight_x;
         gsp_pkg::REG_WEIGHT_Y:   prdata = cfg_ff.weight_y;
         gsp_pkg::REG_WEIGHT_RHO: prdata = cfg_ff.weight_rho;
         gsp_pkg::REG_TOLERANCE:  prdata = {1'b0, cfg_ff.tolerance};
         gsp_pkg::REG_MAX_SWEEPS: prdata = {16'd0, cfg_ff.max_sweeps};
         gsp_pkg::REG_CHECK_INT:  prdata = {16'd0, cfg_ff.check_interval};
         default:                 prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.grid_rows      <= 7'd64;
         cfg_ff.grid_columns   <= 7'd64;
         cfg_ff.weight_x       <= 32'h4000_0000;
         cfg_ff.weight_y       <= 32'h4000_0000;
         cfg_ff.weight_rho     <= 32'd0;
         cfg_ff.tolerance      <= 31'd66;
         cfg_ff.max_sweeps     <= 16'd1000;
         cfg_ff.check_interval <= 16'd10;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> hdl/gsp_ctrl.sv
// ----------------------------------------------------------------------------
// gsp_ctrl
// operation dispatch, sweep/check sequencing and per-cell step control
// ----------------------------------------------------------------------------
module gsp_ctrl #(
   parameter int MAX_ROWS    = gsp_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLUMNS = gsp_pkg::DEF_MAX_COLS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  gsp_pkg::cfg_type               cfg,
   input  logic                           req_valid,
   input  logic [1:0]                     req_operation,
   input  logic [5:0]                     req_row,
   input  logic [5:0]                     req_column,
   output logic                           req_ready,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic                           res_fail,
   output gsp_pkg::cmd_type               cmd,
   output logic [$clog2(MAX_ROWS)-1:0]    cell_i,
   output logic [$clog2(MAX_COLUMNS)-1:0] cell_j
);

   localparam int RW  = $clog2(MAX_ROWS);
   localparam int CW  = $clog2(MAX_COLUMNS);
   localparam int GRW = ($clog2(MAX_ROWS + 1) > 7) ? $clog2(MAX_ROWS + 1) : 7;
   localparam int GCW = ($clog2(MAX_COLUMNS + 1) > 7) ? $clog2(MAX_COLUMNS + 1) : 7;

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_READ     = 3'd1;
   localparam logic [2:0] ST_START    = 3'd2;
   localparam logic [2:0] ST_CELL     = 3'd3;
   localparam logic [2:0] ST_PASS_END = 3'd4;
   localparam logic [2:0] ST_NEXT     = 3'd5;
   localparam logic [2:0] ST_DONE     = 3'd6;

   localparam logic [2:0] SP_UP     = 3'd0;
   localparam logic [2:0] SP_DOWN   = 3'd1;
   localparam logic [2:0] SP_LEFT   = 3'd2;
   localparam logic [2:0] SP_RIGHT  = 3'd3;
   localparam logic [2:0] SP_CENTER = 3'd4;
   localparam logic [2:0] SP_MUL_Y  = 3'd5;
   localparam logic [2:0] SP_ADD_Y  = 3'd6;
   localparam logic [2:0] SP_WRITE  = 3'd7;

   localparam logic MODE_SWEEP = 1'b0;
   localparam logic MODE_CHECK = 1'b1;

   logic [2:0]    state_ff, state_in;
   logic [2:0]    step_ff, step_in;
   logic [RW-1:0] i_ff, i_in;
   logic [CW-1:0] j_ff, j_in;
   logic [15:0]   cnt_ff, cnt_in;
   logic [15:0]   phase_ff, phase_in;
   logic          mode_ff, mode_in;
   logic          fail_ff, fail_in;
   logic          conv_ff, conv_in;
   logic          inside_ff, inside_in;
   logic          valid_ff, valid_in;

   logic [GRW-1:0] eff_rows;
   logic [GCW-1:0] eff_cols;
   logic [RW-1:0]  last_i;
   logic [CW-1:0]  last_j;
   logic           no_interior;
   logic [15:0]    k_eff;
   logic [15:0]    phase_nx;
   logic           out_free;
   logic           req_inside;

   assign eff_rows = (GRW'(cfg.grid_rows) > GRW'(MAX_ROWS)) ? GRW'(MAX_ROWS)
                                                            : GRW'(cfg.grid_rows);
   assign eff_cols = (GCW'(cfg.grid_columns) > GCW'(MAX_COLUMNS)) ? GCW'(MAX_COLUMNS)
                                                                  : GCW'(cfg.grid_columns);
   assign no_interior = (eff_rows < GRW'(3)) || (eff_cols < GCW'(3));
   assign last_i   = RW'(eff_rows - GRW'(2));
   assign last_j   = CW'(eff_cols - GCW'(2));
   assign k_eff    = (cfg.check_interval == 16'd0) ? 16'd1 : cfg.check_interval;
   assign phase_nx = ((17'(phase_ff) + 17'd1) == 17'(k_eff)) ? 16'd0 : phase_ff + 16'd1;
   assign out_free = !valid_ff || rsp_ready;
   assign req_inside = (32'(req_row) < 32'(MAX_ROWS)) && (32'(req_column) < 32'(MAX_COLUMNS));

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = valid_ff;
   assign cell_i    = i_ff;
   assign cell_j    = j_ff;

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      cnt_in    = cnt_ff;
      phase_in  = phase_ff;
      mode_in   = mode_ff;
      fail_in   = fail_ff;
      conv_in   = conv_ff;
      inside_in = inside_ff;
      valid_in  = valid_ff;
      cmd       = '0;
      if (valid_ff && rsp_ready) valid_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_operation)
                  gsp_pkg::OP_LOAD: cmd.load_wr = req_inside;
                  gsp_pkg::OP_READ: begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = gsp_pkg::RS_REQ;
                     inside_in  = req_inside;
                     state_in   = ST_READ;
                  end
                  gsp_pkg::OP_SOLVE: begin
                     cnt_in   = 16'd0;
                     phase_in = 16'd0;
                     conv_in  = 1'b0;
                     state_in = ST_START;
                  end
                  default: ;
               endcase
            end
         end
         ST_READ: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_kind = gsp_pkg::KIND_READ;
               cmd.out_zero = !inside_ff;
               valid_in     = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_START: begin
            if (cfg.max_sweeps == 16'd0) begin
               state_in = ST_DONE;
            end else begin
               mode_in  = MODE_SWEEP;
               i_in     = RW'(1);
               j_in     = CW'(1);
               step_in  = SP_UP;
               state_in = no_interior ? ST_PASS_END : ST_CELL;
            end
         end
         ST_CELL: begin
            step_in = step_ff + 3'd1;
            unique case (step_ff)
               SP_UP: begin
                  cmd.rd_en    = 1'b1;
                  cmd.rd_sel   = gsp_pkg::RS_UP;
                  cmd.ch_rd_en = 1'b1;
               end
               SP_DOWN: begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = gsp_pkg::RS_DOWN;
                  cmd.cap    = gsp_pkg::CAP_SX_LD;
               end
               SP_LEFT: begin
                  cmd.rd_en   = 1'b1;
                  cmd.rd_sel  = gsp_pkg::RS_LEFT;
                  cmd.cap     = gsp_pkg::CAP_SX_ADD;
                  cmd.mul_sel = gsp_pkg::MUL_RHO;
               end
               SP_RIGHT: begin
                  cmd.rd_en   = 1'b1;
                  cmd.rd_sel  = gsp_pkg::RS_RIGHT;
                  cmd.cap     = gsp_pkg::CAP_SY_LD;
                  cmd.mul_sel = gsp_pkg::MUL_X;
                  cmd.acc_op  = gsp_pkg::ACC_LD_RHO;
               end
               SP_CENTER: begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = gsp_pkg::RS_CENTER;
                  cmd.cap    = gsp_pkg::CAP_SY_ADD;
                  cmd.acc_op = gsp_pkg::ACC_ADD_NB;
               end
               SP_MUL_Y: begin
                  cmd.cap     = gsp_pkg::CAP_CENTER;
                  cmd.mul_sel = gsp_pkg::MUL_Y;
               end
               SP_ADD_Y: cmd.acc_op = gsp_pkg::ACC_ADD_NB;
               SP_WRITE: begin
                  if (mode_ff == MODE_SWEEP) cmd.solve_wr = 1'b1;
                  else if (res_fail) fail_in = 1'b1;
                  if (j_ff == last_j) begin
                     j_in = CW'(1);
                     if (i_ff == last_i) state_in = ST_PASS_END;
                     else i_in = i_ff + RW'(1);
                  end else begin
                     j_in = j_ff + CW'(1);
                  end
               end
               default: ;
            endcase
         end
         ST_PASS_END: begin
            if (mode_ff == MODE_SWEEP) begin
               cnt_in   = cnt_ff + 16'd1;
               phase_in = phase_nx;
               if (phase_ff == 16'd0) begin
                  mode_in  = MODE_CHECK;
                  fail_in  = 1'b0;
                  i_in     = RW'(1);
                  j_in     = CW'(1);
                  step_in  = SP_UP;
                  state_in = no_interior ? ST_PASS_END : ST_CELL;
               end else begin
                  state_in = ST_NEXT;
               end
            end else if (!fail_ff) begin
               conv_in  = 1'b1;
               state_in = ST_DONE;
            end else begin
               state_in = ST_NEXT;
            end
         end
         ST_NEXT: begin
            if (cnt_ff == cfg.max_sweeps) begin
               state_in = ST_DONE;
            end else begin
               mode_in  = MODE_SWEEP;
               i_in     = RW'(1);
               j_in     = CW'(1);
               step_in  = SP_UP;
               state_in = no_interior ? ST_PASS_END : ST_CELL;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.out_load  = 1'b1;
               cmd.out_kind  = gsp_pkg::KIND_SOLVE;
               cmd.converged = conv_ff;
               cmd.sweeps    = cnt_ff;
               valid_in      = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         step_ff   <= SP_UP;
         i_ff      <= '0;
         j_ff      <= '0;
         cnt_ff    <= 16'd0;
         phase_ff  <= 16'd0;
         mode_ff   <= MODE_SWEEP;
         fail_ff   <= 1'b0;
         conv_ff   <= 1'b0;
         inside_ff <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         step_ff   <= step_in;
         i_ff      <= i_in;
         j_ff      <= j_in;
         cnt_ff    <= cnt_in;
         phase_ff  <= phase_in;
         mode_ff   <= mode_in;
         fail_ff   <= fail_in;
         conv_ff   <= conv_in;
         inside_ff <= inside_in;
         valid_ff  <= valid_in;
      end
   end

endmodule

>>> hdl/gsp_dp.sv
// ----------------------------------------------------------------------------
// gsp_dp
// grid stores, shared multiplier, stencil accumulator and result register
// ----------------------------------------------------------------------------
module gsp_dp #(
   parameter int MAX_ROWS    = gsp_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLUMNS = gsp_pkg::DEF_MAX_COLS
) (
   input  logic                           clock,
   input  gsp_pkg::cfg_type               cfg,
   input  gsp_pkg::cmd_type               cmd,
   input  logic [$clog2(MAX_ROWS)-1:0]    cell_i,
   input  logic [$clog2(MAX_COLUMNS)-1:0] cell_j,
   input  logic [5:0]                     req_row,
   input  logic [5:0]                     req_column,
   input  logic signed [31:0]             req_charge,
   input  logic signed [31:0]             req_potential,
   output logic                           res_fail,
   output logic                           rsp_result_kind,
   output logic signed [31:0]             rsp_potential,
   output logic                           rsp_converged,
   output logic [15:0]                    rsp_sweeps
);

   localparam int RW    = $clog2(MAX_ROWS);
   localparam int CW    = $clog2(MAX_COLUMNS);
   localparam int AW    = RW + CW;
   localparam int DEPTH = 1 << AW;
   localparam int VW    = gsp_pkg::VAL_W;
   localparam int SW    = gsp_pkg::SUM_W;

   logic [VW-1:0] pot_mem [0:DEPTH-1];
   logic [VW-1:0] chg_mem [0:DEPTH-1];

   logic [VW-1:0]        pot_rd_ff;
   logic [VW-1:0]        chg_rd_ff;
   logic [AW-1:0]        rd_addr;
   logic [AW-1:0]        req_addr;
   logic [AW-1:0]        cell_addr;
   logic signed [33:0]   sx_ff, sy_ff;
   logic [VW-1:0]        center_ff;
   logic signed [32:0]   mul_a;
   logic signed [33:0]   mul_b;
   logic signed [66:0]   prod_ff;
   logic signed [66:0]   rnd16, rnd31;
   logic signed [SW-1:0] acc_ff;
   logic signed [SW-1:0] vmax, vmin;
   logic [VW-1:0]        sat_val;
   logic signed [SW:0]   resid, resid_abs;
   logic [31:0]          wx_sat, wy_sat;
   logic signed [33:0]   rd_ext;
   logic                 kind_ff;
   logic [VW-1:0]        pout_ff;
   logic                 conv_ff;
   logic [15:0]          sweeps_ff;

   assign req_addr  = {RW'(req_row), CW'(req_column)};
   assign cell_addr = {cell_i, cell_j};
   assign rd_ext    = {{2{pot_rd_ff[VW-1]}}, pot_rd_ff};

   always_comb begin
      case (cmd.rd_sel)
         gsp_pkg::RS_UP:     rd_addr = {cell_i - RW'(1), cell_j};
         gsp_pkg::RS_DOWN:   rd_addr = {cell_i + RW'(1), cell_j};
         gsp_pkg::RS_LEFT:   rd_addr = {cell_i, cell_j - CW'(1)};
         gsp_pkg::RS_RIGHT:  rd_addr = {cell_i, cell_j + CW'(1)};
         gsp_pkg::RS_CENTER: rd_addr = cell_addr;
         default:            rd_addr = req_addr;
      endcase
   end

   // grid stores
   always_ff @(posedge clock) begin
      if (cmd.load_wr) begin
         pot_mem[req_addr] <= req_potential;
         chg_mem[req_addr] <= req_charge;
      end else if (cmd.solve_wr) begin
         pot_mem[cell_addr] <= sat_val;
      end
      if (cmd.rd_en) pot_rd_ff <= pot_mem[rd_addr];
      if (cmd.ch_rd_en) chg_rd_ff <= chg_mem[cell_addr];
   end

   // x and y weights above one clamp to one
   assign wx_sat = (cfg.weight_x > 32'h8000_0000) ? 32'h8000_0000 : cfg.weight_x;
   assign wy_sat = (cfg.weight_y > 32'h8000_0000) ? 32'h8000_0000 : cfg.weight_y;

   always_comb begin
      case (cmd.mul_sel)
         gsp_pkg::MUL_X: begin
            mul_a = {1'b0, wx_sat};
            mul_b = sx_ff;
         end
         gsp_pkg::MUL_Y: begin
            mul_a = {1'b0, wy_sat};
            mul_b = sy_ff;
         end
         default: begin
            mul_a = {1'b0, cfg.weight_rho};
            mul_b = {{2{chg_rd_ff[VW-1]}}, chg_rd_ff};
         end
      endcase
   end

   // round to nearest, ties up
   assign rnd16 = (prod_ff + 67'sd32768) >>> 16;
   assign rnd31 = (prod_ff + 67'sd1073741824) >>> 31;

   always_ff @(posedge clock) begin
      case (cmd.cap)
         gsp_pkg::CAP_SX_LD:  sx_ff <= rd_ext;
         gsp_pkg::CAP_SX_ADD: sx_ff <= sx_ff + rd_ext;
         gsp_pkg::CAP_SY_LD:  sy_ff <= rd_ext;
         gsp_pkg::CAP_SY_ADD: sy_ff <= sy_ff + rd_ext;
         gsp_pkg::CAP_CENTER: center_ff <= pot_rd_ff;
         default: ;
      endcase
      if (cmd.mul_sel != gsp_pkg::MUL_NONE) prod_ff <= mul_a * mul_b;
      case (cmd.acc_op)
         gsp_pkg::ACC_LD_RHO: acc_ff <= rnd16[SW-1:0];
         gsp_pkg::ACC_ADD_NB: acc_ff <= acc_ff + rnd31[SW-1:0];
         default: ;
      endcase
   end

   // saturate stencil value to value range
   assign vmax = {{(SW-VW+1){1'b0}}, {(VW-1){1'b1}}};
   assign vmin = {{(SW-VW+1){1'b1}}, {(VW-1){1'b0}}};
   assign sat_val = (acc_ff > vmax) ? vmax[VW-1:0] :
                    (acc_ff < vmin) ? vmin[VW-1:0] : acc_ff[VW-1:0];

   // residual against unsaturated stencil value
   assign resid     = {{(SW-VW+1){center_ff[VW-1]}}, center_ff} - {acc_ff[SW-1], acc_ff};
   assign resid_abs = resid[SW] ? -resid : resid;
   assign res_fail  = resid_abs > {{(SW-30){1'b0}}, cfg.tolerance};

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         kind_ff   <= cmd.out_kind;
         pout_ff   <= (cmd.out_kind == gsp_pkg::KIND_READ && !cmd.out_zero) ? pot_rd_ff
                                                                            : '0;
         conv_ff   <= cmd.converged;
         sweeps_ff <= cmd.sweeps;
      end
   end

   assign rsp_result_kind = kind_ff;
   assign rsp_potential   = pout_ff;
   assign rsp_converged   = conv_ff;
   assign rsp_sweeps      = sweeps_ff;

endmodule

>>> hdl/gauss_seidel_poisson_solver.sv
// operations: a load is written at its accept edge and gives no word; a read word is
//   registered from the read state once the word register is free; a solve runs the
//   per-cell steps for every interior cell in each sweep and each check pass
// throughput: loads one per cycle while idle; other operations one at a time, the next
//   accepted once the result word is registered; the single-port potential store sets the pace
// reset: synchronous, active high; resets control and csr only, not datapath or stores
// ----------------------------------------------------------------------------
// gauss_seidel_poisson_solver
// five-point gauss-seidel poisson solver over a grid store, q16.16 values
// ----------------------------------------------------------------------------
module gauss_seidel_poisson_solver #(
   parameter int MAX_ROWS    = gsp_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLUMNS = gsp_pkg::DEF_MAX_COLS
) (
   input  logic                       clock,
   input  logic                       reset,
   gsp_req_if.sink                    req_channel,
   gsp_rsp_if.source                  rsp_channel,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [gsp_pkg::CSR_AW-1:0] paddr,
   input  logic [31:0]                pwdata,
   output logic [31:0]                prdata,
   output logic                       pready
);

   gsp_pkg::cfg_type cfg;
   gsp_pkg::cmd_type cmd;
   logic [$clog2(MAX_ROWS)-1:0]    cell_i;
   logic [$clog2(MAX_COLUMNS)-1:0] cell_j;
   logic res_fail;

   // register file
   gsp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // sequencer: dispatch, sweep/check passes, per-cell steps
   gsp_ctrl #(
      .MAX_ROWS    (MAX_ROWS),
      .MAX_COLUMNS (MAX_COLUMNS)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .req_valid     (req_channel.valid),
      .req_operation (req_channel.operation),
      .req_row       (req_channel.row),
      .req_column    (req_channel.column),
      .req_ready     (req_channel.ready),
      .rsp_valid     (rsp_channel.valid),
      .rsp_ready     (rsp_channel.ready),
      .res_fail      (res_fail),
      .cmd           (cmd),
      .cell_i        (cell_i),
      .cell_j        (cell_j)
   );

   // stores, multiplier, accumulator and result word register
   gsp_dp #(
      .MAX_ROWS    (MAX_ROWS),
      .MAX_COLUMNS (MAX_COLUMNS)
   ) u_dp (
      .clock           (clock),
      .cfg             (cfg),
      .cmd             (cmd),
      .cell_i          (cell_i),
      .cell_j          (cell_j),
      .req_row         (req_channel.row),
      .req_column      (req_channel.column),
      .req_charge      (req_channel.charge_value),
      .req_potential   (req_channel.potential_value),
      .res_fail        (res_fail),
      .rsp_result_kind (rsp_channel.result_kind),
      .rsp_potential   (rsp_channel.potential_out),
      .rsp_converged   (rsp_channel.converged),
      .rsp_sweeps      (rsp_channel.sweeps_done)
   );

endmodule

>>> hdl/gsp_checker.sv
// ----------------------------------------------------------------------------
// gsp_checker
// port-level checks of the solver, bound to the top level
// ----------------------------------------------------------------------------
module gsp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [1:0]  req_operation,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_result_kind,
   input logic        rsp_converged,
   input logic [15:0] rsp_sweeps
);

   // a pending word stays until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response word dropped");

   // read words carry no solve status
   a_read_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == gsp_pkg::KIND_READ |->
         !rsp_converged && rsp_sweeps == 16'd0)
      else $error("read word with solve status");

   // convergence needs at least one sweep
   a_conv_sweeps: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == gsp_pkg::KIND_SOLVE && rsp_converged |->
         rsp_sweeps != 16'd0)
      else $error("converged with no sweep");

   // a solve blocks new words
   a_solve_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_operation == gsp_pkg::OP_SOLVE |=> !req_ready)
      else $error("word accepted during solve");

endmodule

bind gauss_seidel_poisson_solver gsp_checker u_gsp_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_channel.valid),
   .req_ready       (req_channel.ready),
   .req_operation   (req_channel.operation),
   .rsp_valid       (rsp_channel.valid),
   .rsp_ready       (rsp_channel.ready),
   .rsp_result_kind (rsp_channel.result_kind),
   .rsp_converged   (rsp_channel.converged),
   .rsp_sweeps      (rsp_channel.sweeps_done)
);
